@@ src/cti_pkg.sv @@
// shared types, constants and helper functions of the curve table interpolator
package cti_pkg;

    // table geometry
    localparam int MAX_CURVES = 16;
    localparam int MAX_POINTS = 256;
    localparam int CURVE_W    = 4;
    localparam int SLOT_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int ADDR_W     = CURVE_W + SLOT_W;
    localparam int MEM_DEPTH  = MAX_CURVES * MAX_POINTS;

    // data widths
    localparam int DATA_W = 32;
    localparam int ANS_W  = 48;

    // multiply-divide unit widths
    localparam int AW     = 50;
    localparam int BW     = 33;
    localparam int DW     = 33;
    localparam int PW     = AW + BW;
    localparam int NW     = PW + 18;
    localparam int RW     = DW + 2;
    localparam int STEP_W = $clog2(NW + 1);

    localparam logic signed [ANS_W-1:0] Q_ONE   = 48'sd65536;
    localparam logic signed [ANS_W-1:0] ANS_MAX = {1'b0, {(ANS_W-1){1'b1}}};
    localparam logic signed [ANS_W-1:0] ANS_MIN = {1'b1, {(ANS_W-1){1'b0}}};

    // command codes
    localparam logic [2:0] CMD_WRITE     = 3'd0;
    localparam logic [2:0] CMD_VALUE     = 3'd1;
    localparam logic [2:0] CMD_INV_VALUE = 3'd2;
    localparam logic [2:0] CMD_SLOPE     = 3'd3;
    localparam logic [2:0] CMD_INV_SLOPE = 3'd4;

    // interpolation mode codes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_STEP   = 2'd1;

    // read slot selection
    typedef enum logic [2:0] {
        SL_ZERO,
        SL_ONE,
        SL_LAST,
        SL_NEXT,
        SL_GATH
    } t_slot;

    // operand sets of the multiply-divide unit
    typedef enum logic [2:0] {
        OP_LIN,
        OP_SEG,
        OP_S1,
        OP_S2,
        OP_BLEND
    } t_md_op;

    // result selection
    typedef enum logic [3:0] {
        RS_ONE,
        RS_FAULT,
        RS_MODE_FLT,
        RS_V0,
        RS_VL,
        RS_PV1,
        RS_CONST,
        RS_LIN,
        RS_MD,
        RS_S1,
        RS_BLEND,
        RS_SATSIGN
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic   ld_in;
        logic   wr_pt;
        logic   rd_en;
        t_slot  rd_sel;
        logic   ld_first;
        logic   ld_last;
        logic   set_side;
        logic   idx_inc;
        logic   gath_step;
        logic   md_start;
        t_md_op md_op;
        logic   ld_s1;
        logic   ld_s2;
        logic   out_load;
        t_res   res_sel;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic is_bad_cmd;
        logic is_unity;
        logic few_points;
        logic is_value;
        logic mode_bad;
        logic mode_step;
        logic below;
        logic above;
        logic next_ok;
        logic passes;
        logic gath_done;
        logic sliding;
        logic dw_zero;
        logic md_done;
        logic out_free;
    } t_dp_status;

    // difference of two samples
    function automatic logic signed [DATA_W:0] diff33(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return 33'(a) - 33'(b);
    endfunction

    // clip a grown sum into the answer range
    function automatic logic signed [ANS_W-1:0] sat48(input logic signed [ANS_W:0] v);
        logic signed [ANS_W-1:0] res;
        if (v[ANS_W] != v[ANS_W-1]) begin
            res = v[ANS_W] ? ANS_MIN : ANS_MAX;
        end else begin
            res = v[ANS_W-1:0];
        end
        return res;
    endfunction

    // saturated value carrying the sign of v
    function automatic logic signed [ANS_W-1:0] sat_sign(input logic signed [ANS_W:0] v);
        logic signed [ANS_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else begin
            res = v[ANS_W] ? ANS_MIN : ANS_MAX;
        end
        return res;
    endfunction

endpackage

@@ src/cti_muldiv.sv @@
// shift-add multiplier followed by restoring divider: round(a*b*2^sh/d), saturated
module cti_muldiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [cti_pkg::AW-1:0]     i_a,
    input  logic signed [cti_pkg::BW-1:0]     i_b,
    input  logic signed [cti_pkg::DW-1:0]     i_d,
    input  logic                              i_sh16,
    output logic                              o_done,
    output logic signed [cti_pkg::ANS_W-1:0]  o_q
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_PREP,
        M_DIV,
        M_FIN,
        M_DONE
    } t_mstate;

    t_mstate                          r_state;
    logic                             r_neg;
    logic                             r_sh16;
    logic [cti_pkg::PW-1:0]           r_mcand;
    logic [cti_pkg::BW-1:0]           r_mplier;
    logic [cti_pkg::PW-1:0]           r_acc;
    logic [cti_pkg::DW-1:0]           r_ud;
    logic [cti_pkg::NW-1:0]           r_num;
    logic [cti_pkg::RW-1:0]           r_rem;
    logic [cti_pkg::ANS_W:0]          r_quo;
    logic                             r_ovf;
    logic [cti_pkg::STEP_W-1:0]       r_cnt;
    logic signed [cti_pkg::ANS_W-1:0] r_q;

    logic [cti_pkg::AW-1:0] ua;
    logic [cti_pkg::BW-1:0] ub;
    logic [cti_pkg::DW-1:0] ud;
    logic [cti_pkg::RW-1:0] rem_sh;
    logic [cti_pkg::RW-1:0] dv;
    logic [cti_pkg::NW-1:0] prod_sh;
    logic                   big;

    // operand magnitudes, divider step values and overflow test
    always_comb begin
        ua      = i_a[cti_pkg::AW-1] ? cti_pkg::AW'(-i_a) : cti_pkg::AW'(i_a);
        ub      = i_b[cti_pkg::BW-1] ? cti_pkg::BW'(-i_b) : cti_pkg::BW'(i_b);
        ud      = i_d[cti_pkg::DW-1] ? cti_pkg::DW'(-i_d) : cti_pkg::DW'(i_d);
        rem_sh  = {r_rem[cti_pkg::RW-2:0], r_num[cti_pkg::NW-1]};
        dv      = {1'b0, r_ud, 1'b0};
        prod_sh = (cti_pkg::NW'(r_acc) << (r_sh16 ? 17 : 1)) + cti_pkg::NW'(r_ud);
        big     = r_ovf || (r_quo >= (cti_pkg::ANS_W+1)'(49'h1 << 47));
    end

    // sequencer and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        if (i_d == '0) begin
                            if (i_a == '0 || i_b == '0) begin
                                r_q <= '0;
                            end else begin
                                r_q <= (i_a[cti_pkg::AW-1] ^ i_b[cti_pkg::BW-1]) ?
                                       cti_pkg::ANS_MIN : cti_pkg::ANS_MAX;
                            end
                            r_state <= M_DONE;
                        end else begin
                            r_neg    <= i_a[cti_pkg::AW-1] ^ i_b[cti_pkg::BW-1]
                                        ^ i_d[cti_pkg::DW-1];
                            r_sh16   <= i_sh16;
                            r_mcand  <= cti_pkg::PW'(ua);
                            r_mplier <= ub;
                            r_acc    <= '0;
                            r_ud     <= ud;
                            r_cnt    <= cti_pkg::STEP_W'(cti_pkg::BW);
                            r_state  <= M_MUL;
                        end
                    end
                end
                M_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == cti_pkg::STEP_W'(1)) begin
                        r_state <= M_PREP;
                    end
                end
                M_PREP: begin
                    r_num   <= prod_sh;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_ovf   <= 1'b0;
                    r_cnt   <= cti_pkg::STEP_W'(cti_pkg::NW);
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    if (rem_sh >= dv) begin
                        r_rem <= rem_sh - dv;
                        r_quo <= {r_quo[cti_pkg::ANS_W-1:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[cti_pkg::ANS_W-1:0], 1'b0};
                    end
                    r_ovf <= r_ovf | r_quo[cti_pkg::ANS_W];
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == cti_pkg::STEP_W'(1)) begin
                        r_state <= M_FIN;
                    end
                end
                M_FIN: begin
                    if (big) begin
                        r_q <= r_neg ? cti_pkg::ANS_MIN : cti_pkg::ANS_MAX;
                    end else begin
                        r_q <= r_neg ? -cti_pkg::ANS_W'(r_quo) : cti_pkg::ANS_W'(r_quo);
                    end
                    r_state <= M_DONE;
                end
                M_DONE: begin
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == M_DONE);
    assign o_q    = r_q;

endmodule

@@ src/cti_datapath.sv @@
// sample stores, search registers, arithmetic unit and output register
module cti_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cti_pkg::t_ctrl_cmd                   i_cmd,
    output cti_pkg::t_dp_status                  o_status,
    input  logic [2:0]                           i_command,
    input  logic [cti_pkg::CURVE_W-1:0]          i_curve_sel,
    input  logic [cti_pkg::SLOT_W-1:0]           i_point_slot,
    input  logic signed [cti_pkg::DATA_W-1:0]    i_x_coord,
    input  logic signed [cti_pkg::DATA_W-1:0]    i_y_coord,
    input  logic [1:0]                           i_interp_mode,
    input  logic                                 i_ends_curve,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [cti_pkg::ANS_W-1:0]     o_answer,
    output logic                                 o_in_range,
    output logic                                 o_fault
);

    // captured transaction
    logic [2:0]                        r_cmd;
    logic [cti_pkg::CURVE_W-1:0]       r_c;
    logic [cti_pkg::SLOT_W-1:0]        r_slot;
    logic signed [cti_pkg::DATA_W-1:0] r_x;
    logic signed [cti_pkg::DATA_W-1:0] r_y;
    logic [1:0]                        r_mode;
    logic                              r_ends;

    // stores
    logic signed [cti_pkg::DATA_W-1:0] r_abscissa [cti_pkg::MEM_DEPTH];
    logic signed [cti_pkg::DATA_W-1:0] r_ordinate [cti_pkg::MEM_DEPTH];
    logic [cti_pkg::COUNT_W-1:0]       r_count    [cti_pkg::MAX_CURVES];
    logic signed [cti_pkg::DATA_W-1:0] r_rdx;
    logic signed [cti_pkg::DATA_W-1:0] r_rdy;

    // search and gathered points (i-2 .. i+1)
    logic signed [cti_pkg::DATA_W-1:0] r_u0, r_v0, r_ul, r_vl;
    logic [cti_pkg::COUNT_W-1:0]       r_idx;
    logic                              r_clamped;
    logic [2:0]                        r_g;
    logic signed [cti_pkg::DATA_W-1:0] r_pu [4];
    logic signed [cti_pkg::DATA_W-1:0] r_pv [4];
    logic signed [cti_pkg::ANS_W-1:0]  r_s1, r_s2;

    // output register
    logic                              r_ovalid;
    logic signed [cti_pkg::ANS_W-1:0]  r_ans;
    logic                              r_inr;
    logic                              r_flt;

    logic                              inv;
    logic                              rise;
    logic signed [cti_pkg::DATA_W-1:0] q;
    logic signed [cti_pkg::DATA_W-1:0] u_rd, v_rd;
    logic [cti_pkg::COUNT_W-1:0]       n;
    logic [cti_pkg::SLOT_W-1:0]        rd_slot;
    logic [cti_pkg::ADDR_W-1:0]        rd_addr;
    logic [cti_pkg::ADDR_W-1:0]        wr_addr;
    logic signed [cti_pkg::AW-1:0]     md_a;
    logic signed [cti_pkg::BW-1:0]     md_b;
    logic signed [cti_pkg::DW-1:0]     md_d;
    logic                              md_sh16;
    logic                              md_done;
    logic signed [cti_pkg::ANS_W-1:0]  md_q;
    logic signed [cti_pkg::DATA_W:0]   rise_next;
    logic signed [cti_pkg::ANS_W-1:0]  res_ans;
    logic                              res_inr;
    logic                              res_flt;
    logic                              next_ok;

    // query view of the stores
    always_comb begin
        inv     = (r_cmd == cti_pkg::CMD_INV_VALUE) || (r_cmd == cti_pkg::CMD_INV_SLOPE);
        q       = inv ? r_y : r_x;
        u_rd    = inv ? r_rdy : r_rdx;
        v_rd    = inv ? r_rdx : r_rdy;
        n       = r_count[r_c];
        rise    = !inv || (r_u0 < r_ul);
        next_ok = ({1'b0, r_idx} + 10'd1) < {1'b0, n};
    end

    // read slot
    always_comb begin
        unique case (i_cmd.rd_sel)
            cti_pkg::SL_ZERO: rd_slot = '0;
            cti_pkg::SL_ONE:  rd_slot = cti_pkg::SLOT_W'(1);
            cti_pkg::SL_LAST: rd_slot = cti_pkg::SLOT_W'(n - 1'b1);
            cti_pkg::SL_NEXT: rd_slot = cti_pkg::SLOT_W'(r_idx + 1'b1);
            cti_pkg::SL_GATH: rd_slot = cti_pkg::SLOT_W'(r_idx + cti_pkg::COUNT_W'(r_g)
                                                          - cti_pkg::COUNT_W'(2));
            default:          rd_slot = '0;
        endcase
        rd_addr = {r_c, rd_slot};
        wr_addr = {r_c, r_slot};
    end

    // sample stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pt) begin
            r_abscissa[wr_addr] <= r_x;
            r_ordinate[wr_addr] <= r_y;
        end
        if (i_cmd.rd_en) begin
            r_rdx <= r_abscissa[rd_addr];
            r_rdy <= r_ordinate[rd_addr];
        end
    end

    // point counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cti_pkg::MAX_CURVES; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_cmd.wr_pt && r_ends) begin
            r_count[r_c] <= cti_pkg::COUNT_W'(r_slot) + 1'b1;
        end
    end

    // transaction capture, search and gather registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_cmd  <= i_command;
            r_c    <= i_curve_sel;
            r_slot <= i_point_slot;
            r_x    <= i_x_coord;
            r_y    <= i_y_coord;
            r_mode <= i_interp_mode;
            r_ends <= i_ends_curve;
        end
        if (i_cmd.ld_first) begin
            r_u0 <= u_rd;
            r_v0 <= v_rd;
        end
        if (i_cmd.ld_last) begin
            r_ul <= u_rd;
            r_vl <= v_rd;
        end
        if (i_cmd.set_side) begin
            r_clamped <= o_status.below || o_status.above;
            r_idx     <= (!o_status.below && o_status.above) ? n - 1'b1
                                                             : cti_pkg::COUNT_W'(1);
            r_g       <= '0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.gath_step) begin
            if (r_g != 3'd0) begin
                r_pu[2'(r_g - 3'd1)] <= u_rd;
                r_pv[2'(r_g - 3'd1)] <= v_rd;
            end
            if (r_g != 3'd4) begin
                r_g <= r_g + 3'd1;
            end
        end
        if (i_cmd.ld_s1) begin
            r_s1 <= md_q;
        end
        if (i_cmd.ld_s2) begin
            r_s2 <= md_q;
        end
    end

    // operands of the multiply-divide unit
    always_comb begin
        md_a    = cti_pkg::AW'(cti_pkg::diff33(r_pv[2], r_pv[1]));
        md_b    = cti_pkg::diff33(q, r_pu[1]);
        md_d    = cti_pkg::diff33(r_pu[2], r_pu[1]);
        md_sh16 = 1'b0;
        unique case (i_cmd.md_op)
            cti_pkg::OP_LIN: begin
            end
            cti_pkg::OP_SEG: begin
                md_b    = cti_pkg::BW'(1);
                md_sh16 = 1'b1;
            end
            cti_pkg::OP_S1: begin
                md_a    = cti_pkg::AW'(cti_pkg::diff33(r_pv[2], r_pv[0]));
                md_b    = cti_pkg::BW'(1);
                md_d    = cti_pkg::diff33(r_pu[2], r_pu[0]);
                md_sh16 = 1'b1;
            end
            cti_pkg::OP_S2: begin
                md_a    = cti_pkg::AW'(cti_pkg::diff33(r_pv[3], r_pv[1]));
                md_b    = cti_pkg::BW'(1);
                md_d    = cti_pkg::diff33(r_pu[3], r_pu[1]);
                md_sh16 = 1'b1;
            end
            cti_pkg::OP_BLEND: begin
                md_a = cti_pkg::AW'(49'(r_s2) - 49'(r_s1));
            end
            default: begin
            end
        endcase
    end

    cti_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.md_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .i_sh16  (md_sh16),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    // result selection
    always_comb begin
        rise_next = next_ok ? cti_pkg::diff33(r_pv[3], r_pv[2])
                            : cti_pkg::diff33(r_pv[2], r_pv[1]);
        res_inr   = !r_clamped;
        res_flt   = 1'b0;
        unique case (i_cmd.res_sel)
            cti_pkg::RS_ONE: begin
                res_ans = cti_pkg::Q_ONE;
                res_inr = 1'b1;
            end
            cti_pkg::RS_FAULT: begin
                res_ans = '0;
                res_inr = 1'b0;
                res_flt = 1'b1;
            end
            cti_pkg::RS_MODE_FLT: begin
                res_ans = '0;
                res_flt = 1'b1;
            end
            cti_pkg::RS_V0:       res_ans = cti_pkg::ANS_W'(r_v0);
            cti_pkg::RS_VL:       res_ans = cti_pkg::ANS_W'(r_vl);
            cti_pkg::RS_PV1:      res_ans = cti_pkg::ANS_W'(r_pv[1]);
            cti_pkg::RS_CONST:    res_ans = cti_pkg::ANS_W'(inv ? r_pv[2] : r_pv[1]);
            cti_pkg::RS_LIN:      res_ans = cti_pkg::sat48(49'(r_pv[1]) + 49'(md_q));
            cti_pkg::RS_MD:       res_ans = md_q;
            cti_pkg::RS_S1:       res_ans = r_s1;
            cti_pkg::RS_BLEND:    res_ans = cti_pkg::sat48(49'(r_s1) + 49'(md_q));
            cti_pkg::RS_SATSIGN:  res_ans = cti_pkg::sat_sign(49'(rise_next));
            default:              res_ans = '0;
        endcase
    end

    // output register, freed when the receiver takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ans <= res_ans;
            r_inr <= res_inr;
            r_flt <= res_flt;
        end
    end

    // status to the controller
    always_comb begin
        o_status.is_write   = (r_cmd == cti_pkg::CMD_WRITE);
        o_status.is_bad_cmd = (r_cmd > cti_pkg::CMD_INV_SLOPE);
        o_status.is_unity   = (r_c == '0) && (r_cmd != cti_pkg::CMD_INV_VALUE);
        o_status.few_points = (n < cti_pkg::COUNT_W'(2));
        o_status.is_value   = (r_cmd == cti_pkg::CMD_VALUE) ||
                              (r_cmd == cti_pkg::CMD_INV_VALUE);
        o_status.mode_bad   = (r_mode != cti_pkg::MODE_LINEAR) &&
                              (r_mode != cti_pkg::MODE_STEP);
        o_status.mode_step  = (r_mode == cti_pkg::MODE_STEP);
        o_status.below      = rise ? (q < r_u0) : (q > r_u0);
        o_status.above      = rise ? (q > r_ul) : (q < r_ul);
        o_status.next_ok    = next_ok;
        o_status.passes     = rise ? (q > u_rd) : (q < u_rd);
        o_status.gath_done  = (r_g == 3'd4);
        o_status.sliding    = (r_mode == cti_pkg::MODE_STEP) && !r_clamped &&
                              (r_idx > cti_pkg::COUNT_W'(1)) &&
                              (({1'b0, r_idx} + 10'd2) < {1'b0, n});
        o_status.dw_zero    = (r_pu[2] == r_pu[1]);
        o_status.md_done    = md_done;
        o_status.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_answer    = r_ans;
    assign o_in_range  = r_inr;
    assign o_fault     = r_flt;

endmodule

@@ src/cti_ctrl.sv @@
// controller state machine sequencing one transaction at a time
module cti_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cti_pkg::t_dp_status i_status,
    output cti_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD0,
        S_RD1,
        S_CLAMP,
        S_SRCH,
        S_GATH,
        S_PLAN,
        S_MD_GO,
        S_MD_WAIT,
        S_FIN
    } t_state;

    t_state          r_state;
    logic            r_ready;
    cti_pkg::t_res   r_res;
    cti_pkg::t_md_op r_op;

    logic in_range;

    assign in_range = !i_status.below && !i_status.above;

    // commands decoded from the state
    always_comb begin
        o_cmd         = '0;
        o_cmd.ld_in   = i_in_valid && r_ready;
        o_cmd.md_op   = r_op;
        o_cmd.res_sel = r_res;
        unique case (r_state)
            S_DECODE: begin
                if (i_status.is_write) begin
                    o_cmd.wr_pt = 1'b1;
                end else if (!i_status.is_bad_cmd && !i_status.is_unity &&
                             !i_status.few_points) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cti_pkg::SL_ZERO;
                end
            end
            S_RD0: begin
                o_cmd.ld_first = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = cti_pkg::SL_LAST;
            end
            S_RD1: begin
                o_cmd.ld_last = 1'b1;
            end
            S_CLAMP: begin
                o_cmd.set_side = 1'b1;
                if (in_range && !(i_status.is_value && i_status.mode_bad)) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = cti_pkg::SL_ONE;
                end
            end
            S_SRCH: begin
                if (i_status.next_ok && i_status.passes) begin
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = cti_pkg::SL_NEXT;
                end
            end
            S_GATH: begin
                o_cmd.gath_step = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = cti_pkg::SL_GATH;
            end
            S_MD_GO: begin
                o_cmd.md_start = 1'b1;
            end
            S_MD_WAIT: begin
                o_cmd.ld_s1 = i_status.md_done && (r_op == cti_pkg::OP_S1);
                o_cmd.ld_s2 = i_status.md_done && (r_op == cti_pkg::OP_S2);
            end
            S_FIN: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_res   <= cti_pkg::RS_ONE;
            r_op    <= cti_pkg::OP_LIN;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_ready <= 1'b0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    priority if (i_status.is_write || i_status.is_bad_cmd) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (i_status.is_unity) begin
                        r_res   <= cti_pkg::RS_ONE;
                        r_state <= S_FIN;
                    end else if (i_status.few_points) begin
                        r_res   <= cti_pkg::RS_FAULT;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: r_state <= S_CLAMP;
                S_CLAMP: begin
                    if (i_status.is_value) begin
                        priority if (i_status.below) begin
                            r_res   <= cti_pkg::RS_V0;
                            r_state <= S_FIN;
                        end else if (i_status.above) begin
                            r_res   <= cti_pkg::RS_VL;
                            r_state <= S_FIN;
                        end else if (i_status.mode_bad) begin
                            r_res   <= cti_pkg::RS_MODE_FLT;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end else begin
                        r_state <= in_range ? S_SRCH : S_GATH;
                    end
                end
                S_SRCH: begin
                    if (!(i_status.next_ok && i_status.passes)) begin
                        r_state <= S_GATH;
                    end
                end
                S_GATH: begin
                    if (i_status.gath_done) begin
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    if (i_status.is_value) begin
                        priority if (i_status.mode_step) begin
                            r_res   <= cti_pkg::RS_CONST;
                            r_state <= S_FIN;
                        end else if (i_status.dw_zero) begin
                            r_res   <= cti_pkg::RS_PV1;
                            r_state <= S_FIN;
                        end else begin
                            r_op    <= cti_pkg::OP_LIN;
                            r_res   <= cti_pkg::RS_LIN;
                            r_state <= S_MD_GO;
                        end
                    end else begin
                        priority if (i_status.sliding) begin
                            r_op    <= cti_pkg::OP_S1;
                            r_state <= S_MD_GO;
                        end else if (i_status.dw_zero) begin
                            r_res   <= cti_pkg::RS_SATSIGN;
                            r_state <= S_FIN;
                        end else begin
                            r_op    <= cti_pkg::OP_SEG;
                            r_res   <= cti_pkg::RS_MD;
                            r_state <= S_MD_GO;
                        end
                    end
                end
                S_MD_GO: r_state <= S_MD_WAIT;
                S_MD_WAIT: begin
                    if (i_status.md_done) begin
                        priority if (r_op == cti_pkg::OP_S1) begin
                            r_op    <= cti_pkg::OP_S2;
                            r_state <= S_MD_GO;
                        end else if (r_op == cti_pkg::OP_S2) begin
                            if (i_status.dw_zero) begin
                                r_res   <= cti_pkg::RS_S1;
                                r_state <= S_FIN;
                            end else begin
                                r_op    <= cti_pkg::OP_BLEND;
                                r_res   <= cti_pkg::RS_BLEND;
                                r_state <= S_MD_GO;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (i_status.out_free) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_ready <= 1'b1;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = r_ready;

endmodule

@@ src/curve_table_interpolator_top.sv @@
// top level of the curve table interpolator
//
// Input channel s_*: one transaction per command. s_tuser carries the command
// (write point, value, inverse value, slope, inverse slope), s_tlast marks the
// last point of a curve on a write, s_tdata the curve, slot, x, y and mode.
// Output channel m_*: one transaction per query; writes and unknown commands
// give none. m_tdata carries the Q32.16 answer, m_tuser the in-range and fault
// flags.
// Transactions are handled one at a time. A write or an unknown command ends
// after decode. A query on curve zero (other than an inverse value) or one that
// faults on its point count goes straight to its result, a clamped value or a
// value with a bad mode follows the reads of the first and last points, and any
// other query runs a linear search over the table points and then passes through
// the serial multiply-divide unit none, one, two or three times (two or three for
// a sliding slope). The input is ready again as the result is loaded. The search
// loop and the bit-serial divider set how long a query takes.
// Reset clears the point counts and the output valid flag; sample stores keep
// their contents and are defined only once written.
// A finished result sits in the output register; the next transaction is
// accepted while it waits, and the block stalls only when a second result
// is ready before the receiver has taken the first.
module curve_table_interpolator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // curve_sel[3:0], point_slot[11:4], x_coord[43:12],
                                   // y_coord[75:44], interp_mode[77:76], zero pad
    input  logic [2:0]  s_tuser,   // command[2:0]
    input  logic        s_tlast,   // ends_curve
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // answer[47:0]
    output logic [1:0]  m_tuser    // in_range[0], fault[1]
);

    cti_pkg::t_ctrl_cmd               cmd;
    cti_pkg::t_dp_status              status;
    logic signed [cti_pkg::ANS_W-1:0] answer;
    logic                             in_range;
    logic                             fault;

    cti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cti_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_command     (s_tuser),
        .i_curve_sel   (s_tdata[3:0]),
        .i_point_slot  (s_tdata[11:4]),
        .i_x_coord     (s_tdata[43:12]),
        .i_y_coord     (s_tdata[75:44]),
        .i_interp_mode (s_tdata[77:76]),
        .i_ends_curve  (s_tlast),
        .i_out_ready   (m_tready),
        .o_out_valid   (m_tvalid),
        .o_answer      (answer),
        .o_in_range    (in_range),
        .o_fault       (fault)
    );

    // output packing
    assign m_tdata = answer;
    assign m_tuser = {fault, in_range};

endmodule

@@ src/cti_checker.sv @@
// port-level checks of the curve table interpolator, bound to the top level
module cti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on the cycle after an accepted transaction");

    // no result can appear on the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early after an accept");

    // a faulted answer is zero
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 48'd0)
        else $error("fault with a non-zero answer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output transaction changed");

endmodule

bind curve_table_interpolator_top cti_checker u_cti_checker (.*);
